// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the pacer top-level RTL; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== hw/rtl/prrq_pkg.sv =====
// ----------------------------------------------------------------------------
// Pacer package
// Types, codes and fixed widths shared by the paced release queue.
// ----------------------------------------------------------------------------
package prrq_pkg;

    localparam int TIME_W = 64;
    localparam int ID_W   = 32;
    localparam int CFG_W  = 31;
    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_QUEUED   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASED = 2'd2;

    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic CFG_DELAY = 1'b0;
    localparam logic CFG_PROC  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARR_CMP,
        S_ARR_ADD1,
        S_ARR_ADD2,
        S_ARR_EMIT,
        S_REJ,
        S_T_READ,
        S_T_CMP,
        S_T_FLUSH
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [TIME_W-1:0] sum;
        logic              carry;
    } alu_rsp_t;

endpackage

// ===== hw/rtl/prrq_alu.sv =====
// ----------------------------------------------------------------------------
// Shared adder
// One 64-bit add/subtract with carry out, used for saturating sums and
// for deadline comparisons.
// ----------------------------------------------------------------------------
module prrq_alu (
    input  prrq_pkg::alu_req_t req,
    output prrq_pkg::alu_rsp_t rsp
);
    import prrq_pkg::*;

    logic [TIME_W-1:0] b_x;
    logic              cin;
    logic [TIME_W:0]   total;

    always_comb begin
        b_x = (req.op == ALU_SUB) ? ~req.b : req.b;
        cin = (req.op == ALU_SUB);
    end

    assign total     = {1'b0, req.a} + {1'b0, b_x} + {{TIME_W{1'b0}}, cin};
    assign rsp.sum   = total[TIME_W-1:0];
    assign rsp.carry = total[TIME_W];

endmodule

// ===== hw/rtl/prrq_store.sv =====
// ----------------------------------------------------------------------------
// Entry store
// Id and deadline memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module prrq_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [prrq_pkg::ID_W-1:0]   wr_id,
    input  logic [prrq_pkg::TIME_W-1:0] wr_dl,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [prrq_pkg::ID_W-1:0]   rd_id,
    output logic [prrq_pkg::TIME_W-1:0] rd_dl
);
    import prrq_pkg::*;

    logic [ID_W-1:0]   id_mem [DEPTH];
    logic [TIME_W-1:0] dl_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            id_mem[wr_addr] <= wr_id;
            dl_mem[wr_addr] <= wr_dl;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_id <= id_mem[rd_addr];
            rd_dl <= dl_mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/paced_request_release_queue.sv =====
// ----------------------------------------------------------------------------
// Paced request release queue
// Leaky-bucket pacer: assigns release deadlines to requests, queues them and
// releases due entries in order on timer ticks.
// ----------------------------------------------------------------------------
// Items are taken one at a time; s_tready is high only while the sequencer is
// idle. All deadline arithmetic goes through one shared 64-bit adder, one
// step per cycle. An arrival runs a compare, one saturating add, or two when
// the last deadline is still ahead, and a write; a rejection only emits its
// result. A tick releases entries until the queue is empty, the release
// limit is reached or an entry is not yet due: each release is a registered
// memory read followed by a compare. A result waiting in the output register
// stalls the sequencer only when a further result is ready to replace it.
`include "assert_macros.svh"

module paced_request_release_queue #(
    parameter int QUEUE_DEPTH  = 1024,
    parameter int MAX_RELEASES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // request_id [31:0], now_us [95:32]
    input  logic [0:0]  s_tuser,   // op [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // result_id [31:0], deadline_us [95:32]
    output logic [1:0]  m_tuser,   // kind [1:0]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [30:0] cfg_data
);
    import prrq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int REL_W = $clog2(MAX_RELEASES + 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [REL_W-1:0] REL_MAX  = REL_W'(MAX_RELEASES);

    state_t            state_reg, state_next;
    logic [TIME_W-1:0] now_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] acc_reg;
    logic              gt_reg;
    logic [PTR_W-1:0]  head_reg, tail_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [TIME_W-1:0] last_reg;
    logic [CFG_W-1:0]  delay_reg, proc_reg;
    logic [REL_W-1:0]  n_reg;
    logic              pend_valid_reg;
    logic [ID_W-1:0]   pend_id_reg;
    logic [TIME_W-1:0] pend_dl_reg;
    logic              out_valid_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [TIME_W-1:0] out_dl_reg;
    logic              out_last_reg;

    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;
    logic [TIME_W-1:0] sat_sum;
    logic              due;
    logic              out_free;
    logic              s_accept;
    logic              rd_en, wr_en, emit, rel_take, acc_load, gt_load;
    logic [KIND_W-1:0] e_kind;
    logic [ID_W-1:0]   e_id;
    logic [TIME_W-1:0] e_dl;
    logic              e_last;
    logic [ID_W-1:0]   rd_id;
    logic [TIME_W-1:0] rd_dl;

    prrq_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    prrq_store #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (PTR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_id   (id_reg),
        .wr_dl   (acc_reg),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_id   (rd_id),
        .rd_dl   (rd_dl)
    );

    assign sat_sum  = alu_rsp.carry ? {TIME_W{1'b1}} : alu_rsp.sum;
    assign due      = !alu_rsp.carry;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_dl_reg, out_id_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        alu_req  = '{op: ALU_ADD, a: '0, b: '0};
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        emit     = 1'b0;
        rel_take = 1'b0;
        acc_load = 1'b0;
        gt_load  = 1'b0;
        e_kind   = KIND_QUEUED;
        e_id     = id_reg;
        e_dl     = acc_reg;
        e_last   = 1'b1;
        unique case (state_reg)
            S_IDLE: begin
            end
            S_ARR_CMP: begin
                alu_req = '{op: ALU_SUB, a: now_reg, b: last_reg};
                gt_load = 1'b1;
            end
            S_ARR_ADD1: begin
                if (gt_reg) begin
                    alu_req = '{op: ALU_ADD, a: last_reg,
                                b: {{(TIME_W-CFG_W){1'b0}}, delay_reg}};
                end else begin
                    alu_req = '{op: ALU_ADD, a: now_reg,
                                b: {{(TIME_W-CFG_W){1'b0}}, proc_reg}};
                end
                acc_load = 1'b1;
            end
            S_ARR_ADD2: begin
                alu_req  = '{op: ALU_ADD, a: acc_reg,
                             b: {{(TIME_W-CFG_W){1'b0}}, proc_reg}};
                acc_load = 1'b1;
            end
            S_ARR_EMIT: begin
                if (out_free) begin
                    wr_en = 1'b1;
                    emit  = 1'b1;
                end
            end
            S_REJ: begin
                e_kind = KIND_REJECTED;
                e_dl   = '0;
                emit   = out_free;
            end
            S_T_READ: begin
                rd_en = (count_reg != '0) && (n_reg < REL_MAX);
            end
            S_T_CMP: begin
                alu_req = '{op: ALU_SUB, a: rd_dl, b: now_reg};
                e_kind  = KIND_RELEASED;
                e_id    = pend_id_reg;
                e_dl    = pend_dl_reg;
                e_last  = 1'b0;
                if (due && (!pend_valid_reg || out_free)) begin
                    rel_take = 1'b1;
                    emit     = pend_valid_reg;
                end
            end
            S_T_FLUSH: begin
                e_kind = KIND_RELEASED;
                e_id   = pend_id_reg;
                e_dl   = pend_dl_reg;
                emit   = pend_valid_reg && out_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == OP_TICK) begin
                        state_next = S_T_READ;
                    end else if (count_reg == DEPTH_C) begin
                        state_next = S_REJ;
                    end else begin
                        state_next = S_ARR_CMP;
                    end
                end
            end
            S_ARR_CMP:  state_next = S_ARR_ADD1;
            S_ARR_ADD1: state_next = gt_reg ? S_ARR_ADD2 : S_ARR_EMIT;
            S_ARR_ADD2: state_next = S_ARR_EMIT;
            S_ARR_EMIT: if (out_free) state_next = S_IDLE;
            S_REJ:      if (out_free) state_next = S_IDLE;
            S_T_READ:   state_next = rd_en ? S_T_CMP : S_T_FLUSH;
            S_T_CMP: begin
                if (!due) begin
                    state_next = S_T_FLUSH;
                end else if (rel_take) begin
                    state_next = S_T_READ;
                end
            end
            S_T_FLUSH: if (!pend_valid_reg || out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            last_reg       <= '0;
            delay_reg      <= CFG_W'(500);
            proc_reg       <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index[0])
                    CFG_DELAY: delay_reg <= cfg_data;
                    CFG_PROC:  proc_reg  <= cfg_data;
                    default:   delay_reg <= delay_reg;
                endcase
            end
            if (s_accept) begin
                n_reg <= '0;
            end
            if (wr_en) begin
                tail_reg  <= (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                count_reg <= count_reg + 1'b1;
                last_reg  <= acc_reg;
            end
            if (rel_take) begin
                head_reg       <= (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                count_reg      <= count_reg - 1'b1;
                n_reg          <= n_reg + 1'b1;
                pend_valid_reg <= 1'b1;
            end else if (state_reg == S_T_FLUSH && emit) begin
                pend_valid_reg <= 1'b0;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            now_reg <= s_tdata[95:32];
            id_reg  <= s_tdata[31:0];
        end
        if (gt_load) begin
            gt_reg <= !alu_rsp.carry;
        end
        if (acc_load) begin
            acc_reg <= sat_sum;
        end
        if (rel_take) begin
            pend_id_reg <= rd_id;
            pend_dl_reg <= rd_dl;
        end
        if (emit) begin
            out_kind_reg <= e_kind;
            out_id_reg   <= e_id;
            out_dl_reg   <= e_dl;
            out_last_reg <= e_last;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= DEPTH_C)
    `ASSERT_IMPL(a_ptr_match, aclk, aresetn,
                 (count_reg == '0) || (count_reg == DEPTH_C), head_reg == tail_reg)
    `ASSERT_ALWAYS(a_rel_bound, aclk, aresetn, n_reg <= REL_MAX)
    `ASSERT_IMPL(a_idle_no_pend, aclk, aresetn, state_reg == S_IDLE, !pend_valid_reg)
    `ASSERT_IMPL(a_emit_slot, aclk, aresetn, emit, out_free)

endmodule
